@@ rtl/bbsp_pkg.sv @@
package bbsp_pkg;

  typedef struct packed {
    logic [7:0] sprite_cell_x;
    logic [7:0] sprite_cell_y;
  } in_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] depth;
    logic signed [15:0] center_col;
    logic [15:0]        sprite_size;
    logic [11:0]        row_start;
    logic [11:0]        row_end;
    logic [11:0]        col_start;
    logic signed [15:0] col_end;
  } out_t;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ScreenW  = 13;

  localparam logic [CfgAddrW-1:0] CFG_CAM_POS_X   = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_CAM_POS_Y   = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_VIEW_DIR_X  = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_VIEW_DIR_Y  = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_CAM_PLANE_X = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_CAM_PLANE_Y = 3'd5;
  localparam logic [CfgAddrW-1:0] CFG_SCREEN_W    = 3'd6;
  localparam logic [CfgAddrW-1:0] CFG_SCREEN_H    = 3'd7;

  localparam logic [ScreenW-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [ScreenW-1:0] SCREEN_H_RST = 13'd480;

endpackage

@@ rtl/bbsp_div.sv @@
module bbsp_div #(
  parameter int unsigned NW = 57,
  parameter int unsigned DW = 33,
  parameter int unsigned QW = 32,
  parameter int unsigned SW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  // restoring division, one quotient bit per stage
  localparam int unsigned RW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_q  [QW+1];
  logic [RW-1:0] rem_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic          ovf_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  // quotient too big for QW bits
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= RW'(num_i);
    den_q[0]  <= den_i;
    quo_q[0]  <= '0;
    ovf_q[0]  <= RW'(num_i) >= (RW'(den_i) << QW);
    side_q[0] <= side_i;
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    localparam int unsigned K = QW - i;
    logic [RW-1:0] dsh;
    logic          take;
    logic [QW-1:0] qset;

    assign dsh  = RW'(den_q[i-1]) << K;
    assign take = rem_q[i-1] >= dsh;
    assign qset = quo_q[i-1] | (QW'(take) << K);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]    <= take ? rem_q[i-1] - dsh : rem_q[i-1];
      den_q[i]    <= den_q[i-1];
      quo_q[i]    <= qset;
      ovf_q[i]    <= ovf_q[i-1];
      side_q[i]   <= side_q[i-1];
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

endmodule

@@ rtl/billboard_sprite_projection_top.sv @@
// Sprite projection for a ray-casting renderer.
// Input: start with in_i (sprite map cell). busy stays low, so a new cell
// may be started in every clock cycle; each sprite is independent.
// Output: res_strobe_o is high for one cycle with res_o carrying depth,
// screen column, size, clamped row and column bounds and the visible flag.
// The receiver cannot hold results off and the block never needs it to.
// The pipeline is built from two chained pairs of pipelined restoring
// dividers (33 stages each for transform X and depth, 17 each for column
// and size, input register included) plus ten arithmetic stages.
// Throughput: one sprite per cycle.
// Configuration: cfg_valid_i/cfg_addr_i/cfg_wdata_i, always ready; writes
// go straight to the camera and screen registers and must only happen with
// no sprite in flight.
// Reset clears the pipeline valid bits, camera vectors to zero and the
// screen to 640 by 480.
module billboard_sprite_projection_top #(
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  bbsp_pkg::in_t                       in_i,
  output logic                                res_strobe_o,
  output bbsp_pkg::out_t                      res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bbsp_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [bbsp_pkg::CfgDataW-1:0]       cfg_wdata_i
);
  import bbsp_pkg::*;

  localparam int unsigned F     = COORD_FRAC_BITS;
  localparam int unsigned RXW   = ((F + 8 > 16) ? F + 8 : 16) + 2;
  localparam int unsigned MW    = RXW + 16;
  localparam int unsigned DFW   = MW + 1;
  localparam int unsigned NUMW  = DFW + 30 - F;
  localparam int unsigned LAT   = 4 + 33 + 4 + 17 + 2;

  // configuration registers
  logic        [15:0]        cam_pos_x_q, cam_pos_y_q;
  logic signed [15:0]        dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic        [ScreenW-1:0] screen_w_q, screen_h_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_pos_x_q <= '0;
      cam_pos_y_q <= '0;
      dir_x_q     <= '0;
      dir_y_q     <= '0;
      plane_x_q   <= '0;
      plane_y_q   <= '0;
      screen_w_q  <= SCREEN_W_RST;
      screen_h_q  <= SCREEN_H_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        CFG_CAM_POS_X:   cam_pos_x_q <= cfg_wdata_i;
        CFG_CAM_POS_Y:   cam_pos_y_q <= cfg_wdata_i;
        CFG_VIEW_DIR_X:  dir_x_q     <= $signed(cfg_wdata_i);
        CFG_VIEW_DIR_Y:  dir_y_q     <= $signed(cfg_wdata_i);
        CFG_CAM_PLANE_X: plane_x_q   <= $signed(cfg_wdata_i);
        CFG_CAM_PLANE_Y: plane_y_q   <= $signed(cfg_wdata_i);
        CFG_SCREEN_W:    screen_w_q  <= cfg_wdata_i[ScreenW-1:0];
        CFG_SCREEN_H:    screen_h_q  <= cfg_wdata_i[ScreenW-1:0];
        default: ;
      endcase
    end
  end

  // valid bits of the stages around the dividers
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic vda, vdb, vdc, vdd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      v1_q  <= start && !busy;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= vda && vdb;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= vdc && vdd;
      v10_q <= v9_q;
    end
  end

  // stage 1: sprite centre relative to camera, det partial products
  logic        [RXW-1:0] cxs, cys, half_c;
  logic signed [RXW-1:0] rx_q, ry_q;
  logic signed [31:0]    p1_q, p2_q;

  assign cxs    = RXW'({in_i.sprite_cell_x, {F{1'b0}}});
  assign cys    = RXW'({in_i.sprite_cell_y, {F{1'b0}}});
  assign half_c = RXW'(1) << (F - 1);

  always_ff @(posedge clk_i) begin
    rx_q <= $signed(cxs + half_c - RXW'(cam_pos_x_q));
    ry_q <= $signed(cys + half_c - RXW'(cam_pos_y_q));
    p1_q <= plane_x_q * dir_y_q;
    p2_q <= dir_x_q * plane_y_q;
  end

  // stage 2: transform products and determinant
  logic signed [MW-1:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [32:0]   det2_q, det3_q;

  always_ff @(posedge clk_i) begin
    m1_q   <= dir_y_q * rx_q;
    m2_q   <= dir_x_q * ry_q;
    m3_q   <= plane_x_q * ry_q;
    m4_q   <= plane_y_q * rx_q;
    det2_q <= $signed({p1_q[31], p1_q}) - $signed({p2_q[31], p2_q});
  end

  // stage 3: numerators
  logic signed [DFW-1:0] nx_q, ny_q;

  always_ff @(posedge clk_i) begin
    nx_q   <= $signed({m1_q[MW-1], m1_q}) - $signed({m2_q[MW-1], m2_q});
    ny_q   <= $signed({m3_q[MW-1], m3_q}) - $signed({m4_q[MW-1], m4_q});
    det3_q <= det2_q;
  end

  // stage 4: magnitudes and signs for the transform dividers
  logic [DFW-1:0] ax_q, ay_q;
  logic [32:0]    adet_q;
  logic [1:0]     sdx_q, sdy_q;

  always_ff @(posedge clk_i) begin
    ax_q   <= nx_q[DFW-1] ? DFW'(0) - $unsigned(nx_q) : $unsigned(nx_q);
    ay_q   <= ny_q[DFW-1] ? DFW'(0) - $unsigned(ny_q) : $unsigned(ny_q);
    adet_q <= det3_q[32] ? 33'(0) - $unsigned(det3_q) : $unsigned(det3_q);
    sdx_q  <= {nx_q[DFW-1] ^ det3_q[32], |nx_q};
    sdy_q  <= {ny_q[DFW-1] ^ det3_q[32], |ny_q};
  end

  logic [31:0] qx, qy;
  logic        ovx, ovy;
  logic [1:0]  sx, sy;

  bbsp_div #(.NW(NUMW), .DW(33), .QW(32), .SW(2)) u_div_tx (
    .clk_i, .rst_ni,
    .valid_i (v4_q),
    .num_i   ({ax_q, {(30 - F){1'b0}}}),
    .den_i   (adet_q),
    .side_i  (sdx_q),
    .valid_o (vda),
    .quo_o   (qx),
    .ovf_o   (ovx),
    .side_o  (sx)
  );

  bbsp_div #(.NW(NUMW), .DW(33), .QW(32), .SW(2)) u_div_ty (
    .clk_i, .rst_ni,
    .valid_i (v4_q),
    .num_i   ({ay_q, {(30 - F){1'b0}}}),
    .den_i   (adet_q),
    .side_i  (sdy_q),
    .valid_o (vdb),
    .quo_o   (qy),
    .ovf_o   (ovy),
    .side_o  (sy)
  );

  function automatic logic [31:0] sat32(logic [31:0] q, logic ovf, logic neg, logic nz);
    logic [31:0] r;
    if (!nz) begin
      r = '0;
    end else if (ovf) begin
      r = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (neg) begin
      r = (q > 32'h8000_0000) ? 32'h8000_0000 : 32'(0) - q;
    end else begin
      r = q[31] ? 32'h7fff_ffff : q;
    end
    return r;
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] q, logic ovf, logic neg, logic nz);
    logic [15:0] r;
    if (!nz) begin
      r = '0;
    end else if (ovf) begin
      r = neg ? 16'h8000 : 16'h7fff;
    end else if (neg) begin
      r = (q > 16'h8000) ? 16'h8000 : 16'(0) - q;
    end else begin
      r = q[15] ? 16'h7fff : q;
    end
    return r;
  endfunction

  // stage 5: signed, saturated transform X and depth
  logic signed [31:0] tx5_q, ty5_q, ty6_q, ty7_q;

  always_ff @(posedge clk_i) begin
    tx5_q <= $signed(sat32(qx, ovx, sx[1], sx[0]));
    ty5_q <= $signed(sat32(qy, ovy, sy[1], sy[0]));
  end

  // stage 6: depth plus transform X
  logic signed [32:0] sum_q;

  always_ff @(posedge clk_i) begin
    sum_q <= $signed({tx5_q[31], tx5_q}) + $signed({ty5_q[31], ty5_q});
    ty6_q <= ty5_q;
  end

  // stage 7: column numerator
  logic signed [45:0] cnum_q;

  always_ff @(posedge clk_i) begin
    cnum_q <= $signed({1'b0, screen_w_q[ScreenW-1:1]}) * sum_q;
    ty7_q  <= ty6_q;
  end

  // stage 8: magnitudes for column and size dividers
  logic [45:0] acn_q;
  logic [31:0] aty_q;
  logic [33:0] sc_q;
  logic [28:0] hnum_q;
  logic        hnz_q;

  always_ff @(posedge clk_i) begin
    acn_q  <= cnum_q[45] ? 46'(0) - $unsigned(cnum_q) : $unsigned(cnum_q);
    aty_q  <= ty7_q[31] ? 32'(0) - $unsigned(ty7_q) : $unsigned(ty7_q);
    sc_q   <= {cnum_q[45] ^ ty7_q[31], |cnum_q, ty7_q};
    hnum_q <= {screen_h_q, 16'b0};
    hnz_q  <= |screen_h_q;
  end

  logic [15:0] qc, qs;
  logic        ovc, ovs;
  logic [33:0] scd;
  logic        hnzd;

  bbsp_div #(.NW(46), .DW(32), .QW(16), .SW(34)) u_div_col (
    .clk_i, .rst_ni,
    .valid_i (v8_q),
    .num_i   (acn_q),
    .den_i   (aty_q),
    .side_i  (sc_q),
    .valid_o (vdc),
    .quo_o   (qc),
    .ovf_o   (ovc),
    .side_o  (scd)
  );

  bbsp_div #(.NW(29), .DW(32), .QW(16), .SW(1)) u_div_size (
    .clk_i, .rst_ni,
    .valid_i (v8_q),
    .num_i   (hnum_q),
    .den_i   (aty_q),
    .side_i  (hnz_q),
    .valid_o (vdd),
    .quo_o   (qs),
    .ovf_o   (ovs),
    .side_o  (hnzd)
  );

  // stage 9: centre column and size
  logic signed [15:0] center9_q;
  logic [15:0]        size9_q;
  logic signed [31:0] ty9_q;

  always_ff @(posedge clk_i) begin
    center9_q <= $signed(sat16(qc, ovc, scd[33], scd[32]));
    size9_q   <= !hnzd ? 16'd0 : (ovs ? 16'hffff : qs);
    ty9_q     <= $signed(scd[31:0]);
  end

  // stage 10: clamped bounds
  out_t res_d, res_q;

  always_comb begin
    logic signed [18:0] hh, hs, hv, wv, cv, rsv, rev, csv, cev;
    hh  = $signed(19'(screen_h_q >> 1));
    hs  = $signed(19'(size9_q >> 1));
    hv  = $signed(19'(screen_h_q));
    wv  = $signed(19'(screen_w_q));
    cv  = 19'(center9_q);
    rsv = hh - hs;
    rev = hh + hs;
    if (rev >= hv) begin
      rev = hv - 19'sd1;
    end
    csv = cv - hs - 19'sd1;
    cev = cv + hs;
    if (cev >= wv) begin
      cev = wv - 19'sd1;
    end
    if (cev > 19'sd4095) begin
      cev = 19'sd4095;
    end
    res_d.visible     = ty9_q > 32'sd0;
    res_d.depth       = ty9_q;
    res_d.center_col  = center9_q;
    res_d.sprite_size = size9_q;
    res_d.row_start   = rsv < 0 ? 12'd0 : (rsv > 19'sd4095 ? 12'd4095 : rsv[11:0]);
    res_d.row_end     = rev < 0 ? 12'd0 : (rev > 19'sd4095 ? 12'd4095 : rev[11:0]);
    res_d.col_start   = csv < 0 ? 12'd0 : (csv > 19'sd4095 ? 12'd4095 : csv[11:0]);
    res_d.col_end     = $signed(cev[15:0]);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_strobe_o = v10_q;
  assign res_o        = res_q;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT res_strobe_o)
    else $error("word lost in pipeline");

  a_visible : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.visible == (res_o.depth > 32'sd0)))
    else $error("visible flag disagrees with depth");

  a_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.row_start <= res_o.row_end))
    else $error("row bounds out of order");

  a_div_sync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vda == vdb) && (vdc == vdd))
    else $error("divider pair out of step");
`endif

endmodule
